>>> hw/rtl/gie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gie_pkg : shared types and constants for the genomic inbreeding estimators
// Beat layouts, controller commands and status, divide operation codes and
// the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package gie_pkg;

  localparam int FRAC_BITS = 16;
  localparam int P_W       = 17;
  localparam int CNT_W     = 21;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 42;
  localparam int NUM_W     = 50;
  localparam int DVD_W     = 64;
  localparam int DEN_W     = 48;
  localparam int REM_W     = 48;
  localparam int QUO_W     = 41;
  localparam int ITER_W    = 7;
  localparam int OUT_W     = 32;

  localparam logic [ITER_W-1:0] ITER_LONG  = 7'd64;
  localparam logic [ITER_W-1:0] ITER_SHORT = 7'd49;
  localparam logic [CNT_W-1:0]  CNT_CAP    = 21'd1048576;
  localparam logic [QUO_W-1:0]  QCAP       = 41'h100_0000_0000;

  // divide operations: per-snp ops below eight, final estimates from eight up
  localparam logic [3:0] OP_VR2H   = 4'd0;
  localparam logic [3:0] OP_Y2     = 4'd1;
  localparam logic [3:0] OP_VR2X   = 4'd2;
  localparam logic [3:0] OP_LH2    = 4'd3;
  localparam logic [3:0] OP_LR     = 4'd4;
  localparam logic [3:0] OP_F_VR1  = 4'd8;
  localparam logic [3:0] OP_F_VR2  = 4'd9;
  localparam logic [3:0] OP_F_Y1   = 4'd10;
  localparam logic [3:0] OP_F_Y2   = 4'd11;
  localparam logic [3:0] OP_F_LH1  = 4'd12;
  localparam logic [3:0] OP_F_LH2  = 4'd13;
  localparam logic [3:0] OP_F_HOM  = 4'd14;
  localparam logic [3:0] OP_F_LR   = 4'd15;

  typedef struct packed {
    logic [2:0]      allele_first;
    logic [2:0]      allele_second;
    logic            snp_usable;
    logic [P_W-1:0]  allele2_freq;
    logic            last_snp;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] f_vr1;
    logic signed [OUT_W-1:0] f_vr2;
    logic signed [OUT_W-1:0] f_yang1;
    logic signed [OUT_W-1:0] f_yang2;
    logic signed [OUT_W-1:0] f_lh1;
    logic signed [OUT_W-1:0] f_lh2;
    logic signed [OUT_W-1:0] f_hom;
    logic signed [OUT_W-1:0] f_lr;
    logic [CNT_W-1:0]        loci_used;
    logic                    divide_fault;
  } out_t;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       div_start;
    logic       take;
    logic       acc;
    logic       out_load;
    logic       clear;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic counted;
    logic het;
    logic last;
    logic div_done;
    logic out_free;
  } stat_t;

  // clamp a one-bit-grown accumulator sum back to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // clamp an estimate to the signed 32-bit output range
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [TERM_W:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[TERM_W:OUT_W-1] != {(TERM_W-OUT_W+2){1'b0}} &&
        v[TERM_W:OUT_W-1] != {(TERM_W-OUT_W+2){1'b1}}) begin
      r = v[TERM_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gie_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gie_div : iterative restoring divider
// One quotient bit per cycle, round half up at the end, result capped at 2^40.
// A short run covers 49 dividend bits, a long run all 64.
// ----------------------------------------------------------------------------
module gie_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        short_run,
  input  logic [gie_pkg::DVD_W-1:0]   dividend,
  input  logic [gie_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [gie_pkg::QUO_W-1:0]   quotient
);
  import gie_pkg::*;

  logic [DVD_W-1:0]  dvd;
  logic [REM_W-1:0]  rem;
  logic [QUO_W:0]    quo;
  logic              ovf;
  logic              busy;
  logic [ITER_W-1:0] cnt;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              qbit;
  logic              round_up;
  logic [QUO_W+1:0]  qsum;

  // one restoring step
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = trial >= {1'b0, divisor};
  end

  // rounding and cap
  always_comb begin
    round_up = {rem, 1'b0} >= {1'b0, divisor};
    qsum     = {1'b0, quo} + {{(QUO_W+1){1'b0}}, round_up};
    quotient = (ovf || quo[QUO_W] || qsum > {2'b00, QCAP}) ? QCAP : qsum[QUO_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= short_run ? ITER_SHORT : ITER_LONG;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= short_run ? {dividend[48:0], 15'b0} : dividend;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo <= {quo[QUO_W-1:0], qbit};
      ovf <= ovf | quo[QUO_W];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gie_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gie_dp : datapath for the genomic inbreeding estimators
// Input capture, per-snp products and terms, accumulators, divide operand
// selection around the shared divider, final estimates and output register.
// ----------------------------------------------------------------------------
module gie_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  gie_pkg::cmd_t         cmd,
  output gie_pkg::stat_t        stat,
  input  gie_pkg::in_t          in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [gie_pkg::P_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gie_pkg::out_t         out_data
);
  import gie_pkg::*;

  localparam logic signed [TERM_W-1:0] SCALE_T = 42'sd65536;
  localparam logic [NUM_W-1:0]         P_SQ_N  = 50'h1_0000_0000;

  logic [P_W-1:0]   min_freq;
  logic [15:0]      m_r, o_r, p_r;
  logic             het_r, counted_r, last_r;
  logic [31:0]      sq_r, h2_r;
  logic [CNT_W-1:0] loci_count, hom_count;
  logic signed [ACC_W-1:0] acc_lr, acc_vr1, acc_vr2, acc_yang1, acc_yang2;
  logic signed [ACC_W-1:0] acc_lh2, acc_exp_hom, acc_exp_het;
  logic signed [TERM_W-1:0] ta, tb, tc;
  logic signed [OUT_W-1:0] fin [8];
  logic             fault;

  logic             cls_ok, hom22, hom11, counted;
  logic [P_W-1:0]   q17, twop;
  logic [15:0]      dabs, msel;
  logic [31:0]      mo;

  logic [32:0]      hsum, v1sum, y1sum;
  logic [16:0]      h;
  logic signed [TERM_W-1:0] t_vr1, t_vr2, t_y1, t_y2, t_lh2, t_lr, t_eh, t_het;

  logic signed [NUM_W-1:0] num, den, num_abs, den_abs;
  logic             sh16, den_zero, neg;
  logic [DVD_W-1:0] dividend;
  logic             div_done;
  logic [QUO_W-1:0] quo;
  logic signed [TERM_W-1:0] v;
  logic signed [TERM_W:0]   post;

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq <= '0;
    end else if (cfg_valid) begin
      min_freq <= cfg_data;
    end
  end

  // genotype class and counting test
  always_comb begin
    hom22  = in_data.allele_first == 3'd2 && in_data.allele_second == 3'd2;
    hom11  = in_data.allele_first == 3'd1 && in_data.allele_second == 3'd1;
    cls_ok = hom22 || hom11 ||
             (in_data.allele_first == 3'd1 && in_data.allele_second == 3'd2) ||
             (in_data.allele_first == 3'd2 && in_data.allele_second == 3'd1);
    counted = in_data.snp_usable && cls_ok && in_data.allele2_freq != '0 &&
              in_data.allele2_freq < 17'h10000 && in_data.allele2_freq >= min_freq;
    q17 = 17'h10000 - in_data.allele2_freq;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      counted_r <= counted;
      last_r    <= in_data.last_snp;
      het_r     <= !(hom22 || hom11);
      p_r       <= in_data.allele2_freq[15:0];
      m_r       <= hom22 ? q17[15:0] : in_data.allele2_freq[15:0];
      o_r       <= hom22 ? in_data.allele2_freq[15:0] : q17[15:0];
    end
  end

  // squared term and 2pq
  always_comb begin
    twop = {p_r, 1'b0};
    dabs = (p_r <= 16'd32768) ? 16'(17'h10000 - twop) : 16'(twop - 17'h10000);
    msel = het_r ? dabs : m_r;
    mo   = m_r * o_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sq_r <= msel * msel;
      h2_r <= {mo[30:0], 1'b0};
    end
  end

  // per-snp terms
  always_comb begin
    hsum  = {1'b0, h2_r} + 33'h8000;
    h     = hsum[32:16];
    v1sum = {1'b0, sq_r} + (het_r ? 33'h8000 : 33'h2000);
    y1sum = {1'b0, sq_r} + 33'h4000;
    t_het = $signed({{(TERM_W-17){1'b0}}, h});
    t_eh  = SCALE_T - t_het;
    t_vr1 = het_r ? $signed({{(TERM_W-17){1'b0}}, v1sum[32:16]})
                  : $signed({{(TERM_W-19){1'b0}}, v1sum[32:14]});
    t_y1  = het_r ? -t_het : $signed({{(TERM_W-18){1'b0}}, y1sum[32:15]});
    t_vr2 = ta;
    t_y2  = het_r ? -SCALE_T : tb;
    t_lh2 = het_r ? tb : '0;
    t_lr  = het_r ? tc : SCALE_T;
  end

  // divide operand selection
  always_comb begin
    num = '0;
    den = '0;
    case (cmd.op)
      OP_VR2H: begin
        num = $signed({33'b0, m_r, 1'b0}) - $signed({34'b0, o_r});
        den = $signed({34'b0, o_r});
      end
      OP_Y2: begin
        num = $signed({34'b0, m_r});
        den = $signed({34'b0, o_r});
      end
      OP_VR2X: begin
        num = $signed({18'b0, sq_r}) - $signed({18'b0, h2_r});
        den = $signed({18'b0, h2_r});
      end
      OP_LH2: begin
        num = $signed(P_SQ_N);
        den = $signed({18'b0, h2_r});
      end
      OP_LR: begin
        num = $signed({18'b0, h2_r});
        den = $signed(P_SQ_N) - $signed({18'b0, h2_r});
      end
      OP_F_VR1: begin
        num = {{2{acc_vr1[ACC_W-1]}}, acc_vr1};
        den = {{2{acc_exp_het[ACC_W-1]}}, acc_exp_het};
      end
      OP_F_VR2: begin
        num = {{2{acc_vr2[ACC_W-1]}}, acc_vr2};
        den = $signed({29'b0, loci_count});
      end
      OP_F_Y1: begin
        num = {{2{acc_yang1[ACC_W-1]}}, acc_yang1};
        den = {{2{acc_exp_het[ACC_W-1]}}, acc_exp_het};
      end
      OP_F_Y2: begin
        num = {{2{acc_yang2[ACC_W-1]}}, acc_yang2};
        den = $signed({29'b0, loci_count});
      end
      OP_F_LH1: begin
        num = $signed({13'b0, hom_count, 16'b0}) - {{2{acc_exp_hom[ACC_W-1]}}, acc_exp_hom};
        den = $signed({13'b0, loci_count, 16'b0}) - {{2{acc_exp_hom[ACC_W-1]}}, acc_exp_hom};
      end
      OP_F_LH2: begin
        num = {{2{acc_lh2[ACC_W-1]}}, acc_lh2};
        den = $signed({29'b0, loci_count});
      end
      OP_F_HOM: begin
        num = $signed({29'b0, hom_count});
        den = $signed({29'b0, loci_count});
      end
      OP_F_LR: begin
        num = {{2{acc_lr[ACC_W-1]}}, acc_lr};
        den = $signed({29'b0, loci_count});
      end
      default: begin
        num = '0;
        den = '0;
      end
    endcase
  end

  // magnitudes and scaling for the divider
  always_comb begin
    sh16     = !(cmd.op[3] && cmd.op[0]);
    num_abs  = num[NUM_W-1] ? -num : num;
    den_abs  = den[NUM_W-1] ? -den : den;
    dividend = sh16 ? {num_abs[47:0], 16'b0} : {15'b0, num_abs[48:0]};
    den_zero = den == '0;
    neg      = num[NUM_W-1] ^ den[NUM_W-1] ^ (cmd.op == OP_LR);
  end

  gie_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .short_run (!cmd.op[3]),
    .dividend  (dividend),
    .divisor   (den_abs[DEN_W-1:0]),
    .done      (div_done),
    .quotient  (quo)
  );

  // signed quotient, zero divisor handling and final offsets
  always_comb begin
    if (den_zero) begin
      v = (num[NUM_W-1]) ? -42'sd2147483648 :
          ((num != '0) ? 42'sd2147483647 : 42'sd0);
    end else begin
      v = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    if (cmd.op == OP_F_VR1) begin
      post = {v[TERM_W-1], v} - 43'sd65536;
    end else if (cmd.op == OP_F_LH2) begin
      post = 43'sd65536 - {v[TERM_W-1], v};
    end else begin
      post = {v[TERM_W-1], v};
    end
  end

  // divide results
  always_ff @(posedge clk) begin
    if (cmd.take && !cmd.op[3]) begin
      if (cmd.op == OP_VR2H || cmd.op == OP_VR2X) begin
        ta <= v;
      end else if (cmd.op == OP_LR) begin
        tc <= v;
      end else begin
        tb <= v;
      end
    end
    if (cmd.take && cmd.op[3]) begin
      fin[cmd.op[2:0]] <= sat32(post);
    end
  end

  // accumulators, counters and fault flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      loci_count  <= '0;
      hom_count   <= '0;
      acc_lr      <= '0;
      acc_vr1     <= '0;
      acc_vr2     <= '0;
      acc_yang1   <= '0;
      acc_yang2   <= '0;
      acc_lh2     <= '0;
      acc_exp_hom <= '0;
      acc_exp_het <= '0;
      fault       <= 1'b0;
    end else begin
      if (cmd.take && cmd.op[3] && den_zero) begin
        fault <= 1'b1;
      end
      if (cmd.acc) begin
        if (loci_count < CNT_CAP) loci_count <= loci_count + 21'd1;
        if (!het_r && hom_count < CNT_CAP) hom_count <= hom_count + 21'd1;
        acc_vr1     <= sat_acc({acc_vr1[ACC_W-1], acc_vr1} +
                               {{(ACC_W+1-TERM_W){t_vr1[TERM_W-1]}}, t_vr1});
        acc_vr2     <= sat_acc({acc_vr2[ACC_W-1], acc_vr2} +
                               {{(ACC_W+1-TERM_W){t_vr2[TERM_W-1]}}, t_vr2});
        acc_yang1   <= sat_acc({acc_yang1[ACC_W-1], acc_yang1} +
                               {{(ACC_W+1-TERM_W){t_y1[TERM_W-1]}}, t_y1});
        acc_yang2   <= sat_acc({acc_yang2[ACC_W-1], acc_yang2} +
                               {{(ACC_W+1-TERM_W){t_y2[TERM_W-1]}}, t_y2});
        acc_lh2     <= sat_acc({acc_lh2[ACC_W-1], acc_lh2} +
                               {{(ACC_W+1-TERM_W){t_lh2[TERM_W-1]}}, t_lh2});
        acc_lr      <= sat_acc({acc_lr[ACC_W-1], acc_lr} +
                               {{(ACC_W+1-TERM_W){t_lr[TERM_W-1]}}, t_lr});
        acc_exp_hom <= sat_acc({acc_exp_hom[ACC_W-1], acc_exp_hom} +
                               {{(ACC_W+1-TERM_W){t_eh[TERM_W-1]}}, t_eh});
        acc_exp_het <= sat_acc({acc_exp_het[ACC_W-1], acc_exp_het} +
                               {{(ACC_W+1-TERM_W){t_het[TERM_W-1]}}, t_het});
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.f_vr1        <= fin[0];
      out_data.f_vr2        <= fin[1];
      out_data.f_yang1      <= fin[2];
      out_data.f_yang2      <= fin[3];
      out_data.f_lh1        <= fin[4];
      out_data.f_lh2        <= fin[5];
      out_data.f_hom        <= fin[6];
      out_data.f_lr         <= fin[7];
      out_data.loci_used    <= loci_count;
      out_data.divide_fault <= fault;
    end
  end

  // status to the controller
  always_comb begin
    stat.counted  = counted_r;
    stat.het      = het_r;
    stat.last     = last_r;
    stat.div_done = div_done;
    stat.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

>>> hw/rtl/gie_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gie_ctrl : sequencer for the genomic inbreeding estimators
// Steps each snp through products and, if it counts, divides and accumulation,
// then on the last snp through the eight final divides and the result beat.
// ----------------------------------------------------------------------------
module gie_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gie_pkg::stat_t stat,
  output gie_pkg::cmd_t  cmd
);
  import gie_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DWAIT  = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state, state_next;
  logic [3:0] op, op_next;

  assign in_ready = state == ST_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (stat.counted) begin
          op_next    = stat.het ? OP_VR2X : OP_VR2H;
          state_next = ST_DSTART;
        end else if (stat.last) begin
          op_next    = OP_F_VR1;
          state_next = ST_DSTART;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          cmd.take   = 1'b1;
          state_next = ST_DSTART;
          case (op)
            OP_VR2H: op_next = OP_Y2;
            OP_VR2X: op_next = OP_LH2;
            OP_LH2:  op_next = OP_LR;
            OP_Y2,
            OP_LR:   state_next = ST_ACC;
            OP_F_LR: state_next = ST_OUT;
            default: op_next = op + 4'd1;
          endcase
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (stat.last) begin
          op_next    = OP_F_VR1;
          state_next = ST_DSTART;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_VR2H;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted beat always goes on to the product step
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_MUL)
    else $error("accepted beat did not reach the product step");

  // the divider only finishes while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == ST_DWAIT)
    else $error("divider finished outside its wait state");

  // a divide never completes in the cycle after it starts
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished too early");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/genomic_inbreeding_estimators.sv
`default_nettype none
// ----------------------------------------------------------------------------
// genomic_inbreeding_estimators : per-individual genomic inbreeding estimates
// Streams one snp per beat, accumulates the estimator sums over counted snps
// and on the last snp returns eight Q16.16 estimates, the locus count and a
// divide fault flag, then clears its sums.
//
//   channel  direction  handshake             beat
//   in       to block   in_valid / in_ready   in_data  (gie_pkg::in_t)
//   out      from block out_valid / out_ready out_data (gie_pkg::out_t)
//   cfg      to block   cfg_valid / cfg_ready cfg_data (min_freq, Q1.16)
//
// one snp at a time: no divide if it does not count, two for a homozygote
// and three for a heterozygote, each in the shared one-bit-per-cycle
// divider; the eight final divides follow the last snp.
// the result waits in the output register while snps are taken in, and the
// result step stalls only while that register is still full.
// synchronous active-high reset clears the sums, counters and min_freq.
// ----------------------------------------------------------------------------
module genomic_inbreeding_estimators (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  gie_pkg::in_t            in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gie_pkg::out_t           out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [gie_pkg::P_W-1:0] cfg_data
);
  import gie_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  gie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath with the shared divider
  gie_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> test/genomic_inbreeding_estimators_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genomic_inbreeding_estimators_tb : self-checking bench for the estimators
// Feeds snp beats from a short directed table, then random individuals, over
// several min_freq settings, with random gaps on the input side and random
// stalls on the result side. Every result beat is compared field by field
// with the expected beat from the table or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module genomic_inbreeding_estimators_tb;

  import gie_pkg::in_t;
  import gie_pkg::out_t;

  localparam longint SCALE_Q    = 64'sd65536;
  localparam longint P_UNIT     = 64'sd65536;
  localparam longint P_UNIT_SQ  = 64'sd4294967296;
  localparam longint SUM_HI     = (64'sd1 <<< 47) - 1;
  localparam longint SUM_LO     = -(64'sd1 <<< 47);
  localparam longint I32_HI     = 64'sd2147483647;
  localparam longint I32_LO     = -64'sd2147483648;
  localparam longint unsigned QUO_LIM = 64'd1 << 40;
  localparam int unsigned COUNT_CAP   = 1048576;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_WAIT  = 800;
  localparam int unsigned RANDOM_SNPS = 2000;

  // allele codes
  localparam logic [2:0] AL_MISSING = 3'd0;
  localparam logic [2:0] AL_MAJOR   = 3'd1;
  localparam logic [2:0] AL_MINOR   = 3'd2;
  localparam logic [2:0] AL_ODD     = 3'd3;
  localparam logic [2:0] AL_HIGH    = 3'd4;
  localparam logic [2:0] AL_TOP     = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gie_pkg::P_W-1:0] cfg_data = '0;

  genomic_inbreeding_estimators u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned thr_freq;
  int unsigned n_loci, n_hom;
  longint s_lr, s_vr1, s_vr2, s_y1, s_y2, s_lh2, s_ehom, s_ehet;

  out_t estimates_due[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit burst_mode = 1'b0;

  typedef struct {
    in_t  snp;
    bit   typed;
    out_t want;
  } row_t;

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // round(a * 2^sh / d) with the quotient capped
  function automatic longint unsigned div_round(longint unsigned a, int sh,
                                                longint unsigned d);
    longint unsigned q, r;
    q = a / d;
    r = a % d;
    if (q > QUO_LIM) q = QUO_LIM;
    for (int i = 0; i < sh; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > QUO_LIM) q = QUO_LIM;
    end
    if (r * 2 >= d) q = q + 1;
    if (q > QUO_LIM) q = QUO_LIM;
    return q;
  endfunction

  function automatic longint quot(longint num, int sh, longint den, ref bit fault);
    longint unsigned un, ud, q;
    bit neg;
    if (den == 0) begin
      fault = 1'b1;
      return num > 0 ? I32_HI : (num < 0 ? I32_LO : 0);
    end
    neg = (num < 0) != (den < 0);
    un = num < 0 ? longint'(-num) : num;
    ud = den < 0 ? longint'(-den) : den;
    q = div_round(un, sh, ud);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sum_sat(longint s, longint t);
    longint v;
    v = s + t;
    if (v > SUM_HI) v = SUM_HI;
    if (v < SUM_LO) v = SUM_LO;
    return v;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > I32_HI) v = I32_HI;
    if (v < I32_LO) v = I32_LO;
    return v[31:0];
  endfunction

  function automatic void clear_sums();
    n_loci = 0; n_hom = 0;
    s_lr = 0; s_vr1 = 0; s_vr2 = 0; s_y1 = 0;
    s_y2 = 0; s_lh2 = 0; s_ehom = 0; s_ehet = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: folds one snp in, returns 1 with the estimates on the last snp
  // ---------------------------------------------------------------------------
  function automatic bit fold_snp(in_t b, output out_t r);
    longint p, q, h2, h, m, o, d, vr1, vr2, y1, y2, lr, lh2;
    longint nl, hm;
    bit hom_g, het_g, spare, fault;
    spare = 1'b0;
    fault = 1'b0;
    r = '0;
    p = longint'(b.allele2_freq);
    hom_g = (b.allele_first == AL_MINOR && b.allele_second == AL_MINOR) ||
            (b.allele_first == AL_MAJOR && b.allele_second == AL_MAJOR);
    het_g = (b.allele_first == AL_MAJOR && b.allele_second == AL_MINOR) ||
            (b.allele_first == AL_MINOR && b.allele_second == AL_MAJOR);
    if (b.snp_usable && p > 0 && p < P_UNIT && p >= thr_freq && (hom_g || het_g)) begin
      q = P_UNIT - p;
      h2 = 2 * p * q;
      h = quot(h2, 16, P_UNIT_SQ, spare);
      lh2 = 0;
      if (hom_g) begin
        // m is the other allele's frequency
        m = (b.allele_first == AL_MINOR) ? q : p;
        o = (b.allele_first == AL_MINOR) ? p : q;
        vr1 = quot(4 * m * m, 16, P_UNIT_SQ, spare);
        vr2 = quot(2 * m - o, 16, o, spare);
        y1 = quot(2 * m * m, 16, P_UNIT_SQ, spare);
        y2 = quot(m, 16, o, spare);
        lr = SCALE_Q;
        if (n_hom < COUNT_CAP) n_hom++;
      end else begin
        d = P_UNIT - 2 * p;
        vr1 = quot(d * d, 16, P_UNIT_SQ, spare);
        vr2 = quot(d * d - h2, 16, h2, spare);
        y1 = -h;
        y2 = -SCALE_Q;
        lh2 = quot(P_UNIT_SQ, 16, h2, spare);
        lr = -quot(h2, 16, P_UNIT_SQ - h2, spare);
      end
      if (n_loci < COUNT_CAP) n_loci++;
      s_vr1 = sum_sat(s_vr1, vr1);
      s_vr2 = sum_sat(s_vr2, vr2);
      s_y1 = sum_sat(s_y1, y1);
      s_y2 = sum_sat(s_y2, y2);
      s_lh2 = sum_sat(s_lh2, lh2);
      s_lr = sum_sat(s_lr, lr);
      s_ehom = sum_sat(s_ehom, SCALE_Q - h);
      s_ehet = sum_sat(s_ehet, h);
    end
    if (!b.last_snp) return 1'b0;
    nl = longint'(n_loci);
    hm = longint'(n_hom);
    r.f_vr1   = clamp32(quot(s_vr1, 16, s_ehet, fault) - SCALE_Q);
    r.f_vr2   = clamp32(quot(s_vr2, 0, nl, fault));
    r.f_yang1 = clamp32(quot(s_y1, 16, s_ehet, fault));
    r.f_yang2 = clamp32(quot(s_y2, 0, nl, fault));
    r.f_lh1   = clamp32(quot(hm * SCALE_Q - s_ehom, 16, nl * SCALE_Q - s_ehom, fault));
    r.f_lh2   = clamp32(SCALE_Q - quot(s_lh2, 0, nl, fault));
    r.f_hom   = clamp32(quot(hm, 16, nl, fault));
    r.f_lr    = clamp32(quot(s_lr, 0, nl, fault));
    r.loci_used = n_loci[20:0];
    r.divide_fault = fault;
    clear_sums();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one snp beat; predicts on acceptance
  task automatic send_snp(in_t b, bit typed = 1'b0, out_t want = '0);
    out_t est;
    int unsigned g;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    if (fold_snp(b, est)) estimates_due.push_back(typed ? want : est);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for every result, then for a non-counting snp still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_min_freq(logic [gie_pkg::P_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    thr_freq = {15'b0, v};
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t mk(logic [2:0] a, logic [2:0] b, logic u,
                             logic [16:0] p, logic last);
    in_t s;
    s.allele_first = a;
    s.allele_second = b;
    s.snp_usable = u;
    s.allele2_freq = p;
    s.last_snp = last;
    return s;
  endfunction

  // random snp: mostly a counted genotype, sometimes noise
  function automatic in_t rand_snp(logic last);
    int unsigned k;
    logic [16:0] p;
    in_t s;
    k = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       p = 17'd1;
      1:       p = 17'd65535;
      default: p = 17'($urandom_range(1, 65535));
    endcase
    if (k < 85) begin
      case ($urandom_range(0, 3))
        0: s = mk(AL_MAJOR, AL_MAJOR, 1'b1, p, last);
        1: s = mk(AL_MINOR, AL_MINOR, 1'b1, p, last);
        2: s = mk(AL_MAJOR, AL_MINOR, 1'b1, p, last);
        default: s = mk(AL_MINOR, AL_MAJOR, 1'b1, p, last);
      endcase
    end else begin
      if ($urandom_range(0, 2) == 0) p = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
      s = mk(3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
             1'($urandom_range(0, 1)), p, last);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, check each beat
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: hold_left <= $urandom_range(1, 3);
        3:       hold_left <= $urandom_range(20, 200);
        default: hold_left <= 0;
      endcase
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && out_ready) begin
      if (estimates_due.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        w = estimates_due.pop_front();
        if (out_data.f_vr1 != w.f_vr1) report_mismatch("f_vr1", out_data.f_vr1, w.f_vr1);
        if (out_data.f_vr2 != w.f_vr2) report_mismatch("f_vr2", out_data.f_vr2, w.f_vr2);
        if (out_data.f_yang1 != w.f_yang1)
          report_mismatch("f_yang1", out_data.f_yang1, w.f_yang1);
        if (out_data.f_yang2 != w.f_yang2)
          report_mismatch("f_yang2", out_data.f_yang2, w.f_yang2);
        if (out_data.f_lh1 != w.f_lh1) report_mismatch("f_lh1", out_data.f_lh1, w.f_lh1);
        if (out_data.f_lh2 != w.f_lh2) report_mismatch("f_lh2", out_data.f_lh2, w.f_lh2);
        if (out_data.f_hom != w.f_hom) report_mismatch("f_hom", out_data.f_hom, w.f_hom);
        if (out_data.f_lr != w.f_lr) report_mismatch("f_lr", out_data.f_lr, w.f_lr);
        if (out_data.loci_used != w.loci_used)
          report_mismatch("loci_used", out_data.loci_used, w.loci_used);
        if (out_data.divide_fault != w.divide_fault)
          report_mismatch("divide_fault", out_data.divide_fault, w.divide_fault);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("genomic_inbreeding_estimators_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t rows[$];
    out_t empty_res, half_res;
    int unsigned sent, len;

    thr_freq = 0;
    clear_sums();
    // nothing counted: every divisor zero
    empty_res = '{f_vr1: -32'sd65536, f_vr2: 0, f_yang1: 0, f_yang2: 0, f_lh1: 0,
                  f_lh2: 32'sd65536, f_hom: 0, f_lr: 0, loci_used: 0, divide_fault: 1'b1};
    // one 22 snp at p = 0.5: every estimate comes out at one
    half_res = '{f_vr1: 32'sd65536, f_vr2: 32'sd65536, f_yang1: 32'sd65536,
                 f_yang2: 32'sd65536, f_lh1: 32'sd65536, f_lh2: 32'sd65536,
                 f_hom: 32'sd65536, f_lr: 32'sd65536, loci_used: 21'd1,
                 divide_fault: 1'b0};

    rows.push_back('{mk(AL_MISSING, AL_MISSING, 1'b1, 17'd30000, 1'b1), 1'b1, empty_res});
    rows.push_back('{mk(AL_MINOR, AL_MINOR, 1'b1, 17'd32768, 1'b1), 1'b1, half_res});
    // snps that add nothing, then the frequency extremes that do count
    rows.push_back('{mk(AL_MAJOR, AL_MAJOR, 1'b1, 17'd0, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MAJOR, AL_MINOR, 1'b1, 17'd65536, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MINOR, AL_MAJOR, 1'b0, 17'd20000, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_ODD, AL_ODD, 1'b1, 17'd100, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_HIGH, AL_HIGH, 1'b1, 17'd40000, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_TOP, AL_MAJOR, 1'b1, 17'd40000, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MAJOR, AL_MISSING, 1'b1, 17'd40000, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MAJOR, AL_MAJOR, 1'b1, 17'd1, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MINOR, AL_MINOR, 1'b1, 17'd65535, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MINOR, AL_MINOR, 1'b1, 17'd1, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MAJOR, AL_MINOR, 1'b1, 17'd1, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MINOR, AL_MAJOR, 1'b1, 17'd65535, 1'b0), 1'b0, '0});
    rows.push_back('{mk(AL_MAJOR, AL_MINOR, 1'b1, 17'd32768, 1'b1), 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_snp(rows[i].snp, rows[i].typed, rows[i].want);
    drain();

    // threshold of one: nothing counts
    write_min_freq(17'd65536);
    send_snp(mk(AL_MINOR, AL_MINOR, 1'b1, 17'd40000, 1'b0));
    send_snp(mk(AL_MAJOR, AL_MAJOR, 1'b1, 17'd65535, 1'b1), 1'b1, empty_res);
    drain();
    write_min_freq(17'd65535);
    send_snp(mk(AL_MINOR, AL_MAJOR, 1'b1, 17'd65535, 1'b0));
    send_snp(mk(AL_MAJOR, AL_MAJOR, 1'b1, 17'd65534, 1'b1));
    drain();
    write_min_freq(17'd0);

    // random individuals, several thresholds
    sent = 0;
    while (sent < RANDOM_SNPS) begin
      if (sent != 0 && $urandom_range(0, 24) == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0:       write_min_freq(17'd0);
          1:       write_min_freq(17'd1);
          2:       write_min_freq(17'd32768);
          3:       write_min_freq(17'($urandom_range(0, 8000)));
          default: write_min_freq(17'($urandom_range(0, 65536)));
        endcase
      end
      burst_mode = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) send_snp(rand_snp(i == len - 1));
      sent += len;
    end

    burst_mode = 1'b0;
    drain();
    if (errors == 0) begin
      $display("genomic_inbreeding_estimators_tb: clean");
    end else begin
      $display("genomic_inbreeding_estimators_tb: errors");
    end
    $finish;
  end

endmodule
